>>> rtl/core/kst_pkg.sv
// Package for the keyboard state tracker: item types, operation and register
// codes, scancode constants and the modifier helper. No dependencies.
`default_nettype none

package kst_pkg;

  localparam int unsigned KEY_COUNT_DEF  = 256;
  localparam int unsigned FIFO_DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    OP_KEY_EVENT  = 3'd0,
    OP_POP        = 3'd1,
    OP_READ_HELD  = 3'd2,
    OP_READ_COUNT = 3'd3,
    OP_FLUSH      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CFG_REPEAT_EN = 2'd0,
    CFG_EDITOR    = 2'd1,
    CFG_DEBUG_EN  = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  localparam logic [7:0] SC_LSHIFT  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT  = 8'h36;
  localparam logic [7:0] SC_LCTRL   = 8'h1D;
  localparam logic [7:0] SC_RCTRL   = 8'h9D;
  localparam logic [7:0] SC_LALT    = 8'h38;
  localparam logic [7:0] SC_RALT    = 8'hB8;
  localparam logic [7:0] SC_DELETE  = 8'hD3;
  localparam logic [7:0] SC_NOQUEUE = 8'hAA;

  // slots in the modifier key flags
  localparam int unsigned MK_LSHIFT = 0;
  localparam int unsigned MK_RSHIFT = 1;
  localparam int unsigned MK_LALT   = 2;
  localparam int unsigned MK_RALT   = 3;
  localparam int unsigned MK_LCTRL  = 4;
  localparam int unsigned MK_RCTRL  = 5;
  localparam int unsigned MK_DELETE = 6;
  localparam int unsigned MK_COUNT  = 7;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         scancode;
    logic               released;
    logic signed [31:0] now;
  } kst_in_t;

  typedef struct packed {
    logic               key_valid;
    logic [11:0]        key_code;
    logic signed [31:0] key_time;
    logic signed [31:0] down_time;
    logic [15:0]        down_count;
    logic [3:0]         mod_state;
    logic [7:0]         last_pressed;
    logic [7:0]         last_released;
  } kst_out_t;

  typedef struct packed {
    logic        pressed;
    logic [31:0] went_down;
    logic [31:0] held;
    logic [15:0] count;
  } key_entry_t;

  typedef struct packed {
    logic [11:0] code;
    logic [31:0] stamp;
  } fifo_entry_t;

  // shift bit 0, alt bit 1, ctrl bit 2, debug bit 3
  function automatic logic [3:0] modifier_bits(input logic [MK_COUNT-1:0] keys,
                                               input logic debug_en);
    logic [3:0] m;
    m[0] = keys[MK_LSHIFT] | keys[MK_RSHIFT];
    m[1] = keys[MK_LALT] | keys[MK_RALT];
    m[2] = keys[MK_LCTRL] | keys[MK_RCTRL];
    m[3] = debug_en & keys[MK_DELETE];
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/keyboard_state_tracker.sv
// Keyboard state tracker top level: per-key memory, code FIFO memory and the
// two-step read-modify-write sequencer. Depends on kst_pkg.
//
// Usage: drive item_i and raise start_i; the item is taken at a rising edge
// with start_i high and busy_o low. Every item gives one result on result_o,
// marked by done_o for one cycle; the receiver cannot stall it.
// Sequence: the key entry and the FIFO head are read from their memories at
// the accept edge, the next cycle modifies and writes back, and done_o is
// high in the cycle after that. The block takes no new item while one is
// executing (busy_o high).
// Flush clears every key: per-key valid bits are dropped and an invalid key
// reads as released, with zero counts and a went-down time equal to the time
// of the last flush. Reset acts as a flush at time zero and also restores the
// registers: repeat_enable 1, editor_mode 0, debug_modifier_enable 1. No
// clearing pass is needed. Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i)
// takes effect at once; the user must write it only while no item is in
// flight. The block does not enforce this.
`default_nettype none

module keyboard_state_tracker #(
  parameter int unsigned KEY_COUNT  = kst_pkg::KEY_COUNT_DEF,
  parameter int unsigned FIFO_DEPTH = kst_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire kst_pkg::kst_in_t item_i,
  output logic                  busy_o,
  output logic                  done_o,
  output kst_pkg::kst_out_t     result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [0:0]       cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(KEY_COUNT);
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  kst_pkg::state_e state_q, state_d;
  kst_pkg::kst_in_t item_q;
  kst_pkg::key_entry_t key_mem [KEY_COUNT];
  kst_pkg::fifo_entry_t fifo_mem [FIFO_DEPTH];
  kst_pkg::key_entry_t key_rd_q, ent, ent_d;
  kst_pkg::fifo_entry_t fifo_rd_q, fifo_wdata;
  kst_pkg::kst_out_t result_q, result_d;

  logic [KEY_COUNT-1:0]         valid_q;
  logic [kst_pkg::MK_COUNT-1:0] mod_keys_q, mod_keys_d;
  logic [31:0]                  flush_time_q;
  logic [PTR_W-1:0]             head_q, head_d, tail_q, tail_d, head_nxt, tail_nxt;
  logic [7:0]                   last_press_q, last_press_d, last_release_q, last_release_d;
  logic                         repeat_en_q, editor_q, debug_en_q;
  logic                         done_q, accept, exec, in_range, key_we, fifo_we, flush;
  logic                         queue;
  logic [IDX_W-1:0]             idx_q;
  logic [3:0]                   mods_new;

  assign accept = start_i && (state_q == kst_pkg::ST_IDLE);
  assign idx_q  = item_q.scancode[IDX_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      kst_pkg::ST_IDLE: if (start_i) state_d = kst_pkg::ST_EXEC;
      kst_pkg::ST_EXEC: state_d = kst_pkg::ST_IDLE;
      default:          state_d = kst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    exec = 1'b0;
    case (state_q)
      kst_pkg::ST_EXEC: exec = 1'b1;
      default:          exec = 1'b0;
    endcase
  end

  assign busy_o   = exec;
  assign done_o   = done_q;
  assign result_o = result_q;

  assign head_nxt = (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  always_comb begin
    in_range = {1'b0, item_q.scancode} < 9'(KEY_COUNT);
    ent = key_rd_q;
    if (!valid_q[idx_q]) begin
      ent.pressed   = 1'b0;
      ent.went_down = flush_time_q;
      ent.held      = '0;
      ent.count     = '0;
    end
    ent_d          = ent;
    key_we         = 1'b0;
    fifo_we        = 1'b0;
    fifo_wdata     = '0;
    flush          = 1'b0;
    queue          = 1'b0;
    mod_keys_d     = mod_keys_q;
    head_d         = head_q;
    tail_d         = tail_q;
    last_press_d   = last_press_q;
    last_release_d = last_release_q;
    result_d       = '0;
    mods_new       = kst_pkg::modifier_bits(mod_keys_q, debug_en_q);

    if (exec) begin
      case (kst_pkg::op_e'(item_q.operation))
        kst_pkg::OP_KEY_EVENT: begin
          if (in_range) begin
            key_we = 1'b1;
            case (item_q.scancode)
              kst_pkg::SC_LSHIFT: mod_keys_d[kst_pkg::MK_LSHIFT] = !item_q.released;
              kst_pkg::SC_RSHIFT: mod_keys_d[kst_pkg::MK_RSHIFT] = !item_q.released;
              kst_pkg::SC_LALT:   mod_keys_d[kst_pkg::MK_LALT]   = !item_q.released;
              kst_pkg::SC_RALT:   mod_keys_d[kst_pkg::MK_RALT]   = !item_q.released;
              kst_pkg::SC_LCTRL:  mod_keys_d[kst_pkg::MK_LCTRL]  = !item_q.released;
              kst_pkg::SC_RCTRL:  mod_keys_d[kst_pkg::MK_RCTRL]  = !item_q.released;
              kst_pkg::SC_DELETE: mod_keys_d[kst_pkg::MK_DELETE] = !item_q.released;
              default: ;
            endcase
            mods_new = kst_pkg::modifier_bits(mod_keys_d, debug_en_q);
            if (item_q.released) begin
              last_release_d = item_q.scancode;
              ent_d.pressed  = 1'b0;
              if (!(editor_q && (mods_new != 4'd0))) begin
                ent_d.held = ent.held + (item_q.now - ent.went_down);
              end
            end else begin
              last_press_d = item_q.scancode;
              queue        = 1'b1;
              if (!ent.pressed) begin
                ent_d.went_down = item_q.now;
                ent_d.pressed   = 1'b1;
                if (ent.count != 16'hFFFF) ent_d.count = ent.count + 16'd1;
              end else if (!repeat_en_q) begin
                queue = 1'b0;
              end
              if (queue && (item_q.scancode != kst_pkg::SC_NOQUEUE) &&
                  (tail_nxt != head_q)) begin
                fifo_we          = 1'b1;
                fifo_wdata.code  = {mods_new, item_q.scancode};
                fifo_wdata.stamp = item_q.now;
                tail_d           = tail_nxt;
              end
            end
          end
        end
        kst_pkg::OP_POP: begin
          if (head_q != tail_q) begin
            result_d.key_valid = 1'b1;
            result_d.key_code  = fifo_rd_q.code;
            result_d.key_time  = fifo_rd_q.stamp;
            head_d             = head_nxt;
          end
        end
        kst_pkg::OP_READ_HELD: begin
          if (in_range && !(editor_q && (mods_new != 4'd0))) begin
            key_we = 1'b1;
            if (!ent.pressed) begin
              result_d.down_time = ent.held;
              ent_d.held         = '0;
            end else begin
              result_d.down_time = item_q.now - ent.went_down;
              ent_d.went_down    = item_q.now;
            end
          end
        end
        kst_pkg::OP_READ_COUNT: begin
          if (in_range) begin
            key_we              = 1'b1;
            result_d.down_count = ent.count;
            ent_d.count         = '0;
          end
        end
        kst_pkg::OP_FLUSH: begin
          flush      = 1'b1;
          mod_keys_d = '0;
          head_d     = '0;
          tail_d     = '0;
          mods_new   = kst_pkg::modifier_bits(mod_keys_d, debug_en_q);
        end
        default: ;
      endcase
    end
    result_d.mod_state     = mods_new;
    result_d.last_pressed  = last_press_d;
    result_d.last_released = last_release_d;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[idx_q] <= ent_d;
    if (accept) key_rd_q <= key_mem[item_i.scancode[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) fifo_mem[tail_q] <= fifo_wdata;
    if (accept) fifo_rd_q <= fifo_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= kst_pkg::ST_IDLE;
      done_q         <= 1'b0;
      valid_q        <= '0;
      mod_keys_q     <= '0;
      flush_time_q   <= '0;
      head_q         <= '0;
      tail_q         <= '0;
      last_press_q   <= '0;
      last_release_q <= '0;
    end else begin
      state_q        <= state_d;
      done_q         <= exec;
      mod_keys_q     <= mod_keys_d;
      head_q         <= head_d;
      tail_q         <= tail_d;
      last_press_q   <= last_press_d;
      last_release_q <= last_release_d;
      if (flush) begin
        valid_q      <= '0;
        flush_time_q <= item_q.now;
      end else if (key_we) begin
        valid_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_en_q <= 1'b1;
      editor_q    <= 1'b0;
      debug_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (kst_pkg::cfg_idx_e'(cfg_idx_i))
        kst_pkg::CFG_REPEAT_EN: repeat_en_q <= cfg_wdata_i[0];
        kst_pkg::CFG_EDITOR:    editor_q    <= cfg_wdata_i[0];
        kst_pkg::CFG_DEBUG_EN:  debug_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
